// File: hdl/spfd_pkg.sv
// Shared types and constants of the servo pulse failsafe fader.
// No dependencies; compiled first.
package spfd_pkg;

	localparam logic [1:0] OP_SET  = 2'd0;
	localparam logic [1:0] OP_DIS  = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	localparam logic [2:0] REG_MIN_PULSE      = 3'd0;
	localparam logic [2:0] REG_MAX_PULSE      = 3'd1;
	localparam logic [2:0] REG_CENTER_PULSE   = 3'd2;
	localparam logic [2:0] REG_TIMEOUT_TICKS  = 3'd3;
	localparam logic [2:0] REG_CHECK_INTERVAL = 3'd4;
	localparam logic [2:0] REG_FADE_STEP      = 3'd5;
	localparam logic [2:0] REG_FAILSAFE_ON    = 3'd6;

	localparam logic [15:0] RST_MIN_PULSE      = 16'd1000;
	localparam logic [15:0] RST_MAX_PULSE      = 16'd2000;
	localparam logic [15:0] RST_CENTER_PULSE   = 16'd1500;
	localparam logic [15:0] RST_TIMEOUT_TICKS  = 16'd500;
	localparam logic [15:0] RST_CHECK_INTERVAL = 16'd50;
	localparam logic [15:0] RST_FADE_STEP      = 16'd20;

	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		K_SET    = 2'd0,
		K_DIS    = 2'd1,
		K_REJECT = 2'd2,
		K_TICK   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  channel;
		logic [15:0] pulse_width;
	} q_entry_t;

	typedef struct packed {
		logic [3:0]  out_channel;
		logic [15:0] out_pulse;
		logic        accepted;
		logic        last;
	} rsp_beat_t;

endpackage

// File: hdl/spfd_ifs.sv
// Channel interfaces: command input, result output, configuration write.
// No dependencies.
interface spfd_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [3:0]  channel;
	logic [15:0] pulse_width;
	modport source(output valid, opcode, channel, pulse_width, input ready);
	modport sink(input valid, opcode, channel, pulse_width, output ready);
endinterface

interface spfd_rsp_if;
	logic        valid;
	logic        ready;
	logic [3:0]  out_channel;
	logic [15:0] out_pulse;
	logic        accepted;
	logic        last;
	modport source(output valid, out_channel, out_pulse, accepted, last, input ready);
	modport sink(input valid, out_channel, out_pulse, accepted, last, output ready);
endinterface

interface spfd_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  addr;
	logic [15:0] data;
	modport source(output valid, addr, data, input ready);
	modport sink(input valid, addr, data, output ready);
endinterface

// File: hdl/spfd_front.sv
// Front end: accepts command beats, classifies them and pushes them to the queue.
// Depends on spfd_pkg and spfd_ifs.
module spfd_front import spfd_pkg::*; #(
	parameter int CHANNELS = 4
) (
	spfd_cmd_if.sink   cmd,
	input  logic       full,
	output logic       push,
	output q_entry_t   entry
);

	logic in_range;

	assign in_range  = {1'b0, cmd.channel} < 5'(CHANNELS);
	assign cmd.ready = !full;

	always_comb begin
		entry.channel     = cmd.channel;
		entry.pulse_width = cmd.pulse_width;
		entry.kind        = K_TICK;
		push              = 1'b0;
		unique case (cmd.opcode)
			OP_SET: begin
				entry.kind = in_range ? K_SET : K_REJECT;
				push       = cmd.valid && !full;
			end
			OP_DIS: begin
				entry.kind = in_range ? K_DIS : K_REJECT;
				push       = cmd.valid && !full;
			end
			OP_TICK: begin
				entry.kind = K_TICK;
				push       = cmd.valid && !full;
			end
			default: begin
				// unused opcode: taken and dropped
				push = 1'b0;
			end
		endcase
	end

endmodule

// File: hdl/spfd_queue.sv
// Short FIFO of classified commands between front and back end.
// Depends on spfd_pkg.
module spfd_queue import spfd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t wdata,
	output logic     full,
	output logic     rvalid,
	output q_entry_t rdata,
	input  logic     pop
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	q_entry_t        mem_q [QDEPTH];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = cnt_q == CW'(QDEPTH);
	assign rvalid  = cnt_q != '0;
	assign rdata   = mem_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && rvalid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(QDEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(QDEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// File: hdl/spfd_back.sv
// Back end: config registers, channel pulse and age stores, failsafe walk, result register.
// Depends on spfd_pkg and spfd_ifs.
module spfd_back import spfd_pkg::*; #(
	parameter int CHANNELS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  q_entry_t   q_entry,
	output logic       q_pop,
	spfd_rsp_if.source rsp,
	spfd_cfg_if.sink   cfg
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [CH_W-1:0] LAST_IDX = CH_W'(CHANNELS - 1);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_WALK  = 3'b010,
		S_FLUSH = 3'b100
	} state_t;

	logic [15:0] min_q, max_q, center_q, timeout_q, interval_q, step_q;
	logic        fs_on_q;

	logic [15:0] pulse_q [CHANNELS];
	logic [15:0] age_q   [CHANNELS];
	logic [15:0] cc_q;
	state_t      st_q;
	logic [CH_W-1:0] idx_q;
	logic        pend_v_q;
	logic [3:0]  pend_ch_q;
	logic [15:0] pend_pw_q;
	logic        out_v_q;
	rsp_beat_t   out_q;

	logic            out_free;
	logic [CH_W-1:0] set_idx;
	logic [15:0]     set_val;
	logic [15:0]     cur, age_cur, diff, nv, fin;
	logic            chg, walk_stall;
	logic [15:0]     cc_inc;
	logic            pass_due;

	function automatic logic [15:0] clamp_pw(input logic [15:0] w, input logic [15:0] lo,
		input logic [15:0] hi);
		logic [15:0] r;
		if (w < lo) begin
			r = lo;
		end else if (w > hi) begin
			r = hi;
		end else begin
			r = w;
		end
		return r;
	endfunction

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q      <= RST_MIN_PULSE;
			max_q      <= RST_MAX_PULSE;
			center_q   <= RST_CENTER_PULSE;
			timeout_q  <= RST_TIMEOUT_TICKS;
			interval_q <= RST_CHECK_INTERVAL;
			step_q     <= RST_FADE_STEP;
			fs_on_q    <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				REG_MIN_PULSE:      min_q      <= cfg.data;
				REG_MAX_PULSE:      max_q      <= cfg.data;
				REG_CENTER_PULSE:   center_q   <= cfg.data;
				REG_TIMEOUT_TICKS:  timeout_q  <= cfg.data;
				REG_CHECK_INTERVAL: interval_q <= cfg.data;
				REG_FADE_STEP:      step_q     <= cfg.data;
				REG_FAILSAFE_ON:    fs_on_q    <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign out_free = !out_v_q || rsp.ready;
	assign q_pop    = (st_q == S_IDLE) && q_valid && out_free;
	assign set_idx  = q_entry.channel[CH_W-1:0];
	assign set_val  = clamp_pw(q_entry.pulse_width, min_q, max_q);
	assign cc_inc   = cc_q + 16'd1;
	assign pass_due = cc_inc >= interval_q;

	// fade unit, one channel per cycle unless a result stall holds the walk
	assign cur     = pulse_q[idx_q];
	assign age_cur = age_q[idx_q];
	always_comb begin
		if (cur > center_q) begin
			diff = cur - center_q;
			nv   = (diff <= step_q) ? center_q : cur - step_q;
		end else begin
			diff = center_q - cur;
			nv   = (diff <= step_q) ? center_q : cur + step_q;
		end
		fin = clamp_pw(nv, min_q, max_q);
	end
	assign chg        = (age_cur >= timeout_q) && (cur != center_q) && (fin != cur);
	assign walk_stall = chg && pend_v_q && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				pulse_q[i] <= RST_CENTER_PULSE;
				age_q[i]   <= '0;
			end
			cc_q      <= '0;
			st_q      <= S_IDLE;
			idx_q     <= '0;
			pend_v_q  <= 1'b0;
			pend_ch_q <= '0;
			pend_pw_q <= '0;
			out_v_q   <= 1'b0;
			out_q     <= '0;
		end else begin
			if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (q_pop) begin
						unique case (q_entry.kind)
							K_SET: begin
								pulse_q[set_idx] <= set_val;
								age_q[set_idx]   <= '0;
								out_v_q <= 1'b1;
								out_q   <= '{q_entry.channel, set_val, 1'b1, 1'b1};
							end
							K_DIS: begin
								pulse_q[set_idx] <= '0;
								out_v_q <= 1'b1;
								out_q   <= '{q_entry.channel, 16'd0, 1'b1, 1'b1};
							end
							K_REJECT: begin
								out_v_q <= 1'b1;
								out_q   <= '{q_entry.channel, 16'd0, 1'b0, 1'b1};
							end
							K_TICK: begin
								for (int i = 0; i < CHANNELS; i++) begin
									if (age_q[i] < timeout_q) begin
										age_q[i] <= age_q[i] + 16'd1;
									end
								end
								if (pass_due) begin
									cc_q <= '0;
									if (fs_on_q) begin
										st_q     <= S_WALK;
										idx_q    <= '0;
										pend_v_q <= 1'b0;
									end
								end else begin
									cc_q <= cc_inc;
								end
							end
							default: ;
						endcase
					end
				end
				S_WALK: begin
					if (!walk_stall) begin
						if (chg) begin
							pulse_q[idx_q] <= fin;
							if (pend_v_q) begin
								out_v_q <= 1'b1;
								out_q   <= '{pend_ch_q, pend_pw_q, 1'b1, 1'b0};
							end
							pend_v_q  <= 1'b1;
							pend_ch_q <= 4'(idx_q);
							pend_pw_q <= fin;
						end
						if (idx_q == LAST_IDX) begin
							st_q <= (pend_v_q || chg) ? S_FLUSH : S_IDLE;
						end else begin
							idx_q <= idx_q + CH_W'(1);
						end
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						out_v_q  <= 1'b1;
						out_q    <= '{pend_ch_q, pend_pw_q, 1'b1, 1'b1};
						pend_v_q <= 1'b0;
						st_q     <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.out_channel = out_q.out_channel;
	assign rsp.out_pulse   = out_q.out_pulse;
	assign rsp.accepted    = out_q.accepted;
	assign rsp.last        = out_q.last;

	a_walk_idx: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_WALK |-> idx_q <= LAST_IDX)
		else $error("walk index past last channel");

	a_flush_pend: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_FLUSH |-> pend_v_q)
		else $error("flush without pending result");

	a_cmd_result: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_entry.kind != K_TICK |=> out_v_q && out_q.last)
		else $error("command gave no final result");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_q.accepted |-> out_q.out_pulse == 16'd0 && out_q.last)
		else $error("rejected beat malformed");

endmodule

// File: hdl/servo_pulse_failsafe_fader_top.sv
// Servo pulse store with fade-to-center failsafe: top level.
// A set or disable command gives one result beat. When a tick triggers a failsafe pass, the
// back end walks the channels one per cycle through a single fade unit, except while a
// result stall holds the walk. A two-entry command queue lets the front keep taking beats
// meanwhile. The single result register holds a beat until it is taken. The next command,
// or a walk step that has a beat to hand over, starts no earlier than the cycle in which
// that beat is taken. Config writes are always taken.
// Depends on spfd_pkg, spfd_ifs, spfd_front, spfd_queue and spfd_back.
module servo_pulse_failsafe_fader_top import spfd_pkg::*; #(
	parameter int CHANNELS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	spfd_cmd_if.sink   cmd,
	spfd_rsp_if.source rsp,
	spfd_cfg_if.sink   cfg
);

	logic     push, full, q_valid, q_pop;
	q_entry_t w_entry, r_entry;

	spfd_front #(.CHANNELS(CHANNELS)) u_front (
		.cmd   (cmd),
		.full  (full),
		.push  (push),
		.entry (w_entry)
	);

	spfd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (w_entry),
		.full   (full),
		.rvalid (q_valid),
		.rdata  (r_entry),
		.pop    (q_pop)
	);

	spfd_back #(.CHANNELS(CHANNELS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_entry (r_entry),
		.q_pop   (q_pop),
		.rsp     (rsp),
		.cfg     (cfg)
	);

endmodule
